// ===== rtl/sitoa_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the default operand width and the ASCII codes; no dependencies.

package sitoa_pkg;

  // Default width of the signed operand.
  localparam int unsigned DefaultValueBits = 32;

  // Width of one packed decimal digit.
  localparam int unsigned DigitBits = 4;

  // Width of an emitted character code.
  localparam int unsigned CharBits = 6;

  // ASCII codes, truncated to the character width.
  localparam logic [CharBits-1:0] CharZero  = 6'h30;
  localparam logic [CharBits-1:0] CharMinus = 6'h2D;

endpackage

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitoa_pkg for the digit width and the character codes.

// Converts one two's complement integer per transaction into its decimal text,
// sent one character per output transaction, most significant first, with a
// leading minus sign for negative values, no leading zeros, and last_char_o set
// on the final character. An item is accepted in the idle state, then put through
// shift-and-add-3 binary to BCD conversion of all VALUE_BITS bits in one shared
// digit adjuster; the sign is then sent when negative, and the digit positions
// (NumDigits = VALUE_BITS*78/256 + 1, so 10 at 32 bits) are visited in turn,
// while leading zeros are skipped and digits are sent as the output frees.
// The input is not ready until the last character has been loaded into the
// output register; that character may wait there while the next item is
// accepted.

module signed_int_to_decimal_ascii_top
  import sitoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DefaultValueBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [CharBits-1:0]          character_o,
  output logic                         last_char_o
);

  // Enough decimal digits for any magnitude of VALUE_BITS bits.
  localparam int unsigned NumDigits = (VALUE_BITS * 78) / 256 + 1;
  localparam int unsigned BcdBits   = NumDigits * DigitBits;
  localparam int unsigned CntBits   = $clog2(VALUE_BITS);
  localparam int unsigned DigCntBits = $clog2(NumDigits);

  localparam logic [CntBits-1:0]    BitCntInit = CntBits'(VALUE_BITS - 1);
  localparam logic [DigCntBits-1:0] DigCntInit = DigCntBits'(NumDigits - 1);

  // Sequencer state codes.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdBits-1:0]    bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic                  started_q, started_d;
  logic [CntBits-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DigCntBits-1:0] dig_cnt_q, dig_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [CharBits-1:0]   char_q, char_d;
  logic                  last_q, last_d;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [BcdBits-1:0]    bcd_adj;
  logic [DigitBits-1:0]  top_digit;
  logic                  out_free;

  // Magnitude of the input; the most negative value maps onto itself,
  // which read as unsigned is exactly its magnitude.
  assign raw = value_i;
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // Shared digit adjuster: add 3 to every BCD digit of 5 or more.
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_q[d*DigitBits +: DigitBits] >= DigitBits'(5)) begin
        bcd_adj[d*DigitBits +: DigitBits] = bcd_q[d*DigitBits +: DigitBits] + DigitBits'(3);
      end else begin
        bcd_adj[d*DigitBits +: DigitBits] = bcd_q[d*DigitBits +: DigitBits];
      end
    end
  end

  assign top_digit  = bcd_q[BcdBits-1 -: DigitBits];
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  // Sequencer and output register loading.
  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    neg_d       = neg_q;
    started_d   = started_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          bin_d     = mag;
          bcd_d     = '0;
          neg_d     = raw[VALUE_BITS-1];
          bit_cnt_d = BitCntInit;
          state_d   = StConv;
        end
      end
      StConv: begin
        bcd_d = {bcd_adj[BcdBits-2:0], bin_q[VALUE_BITS-1]};
        bin_d = bin_q << 1;
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          started_d = 1'b0;
          dig_cnt_d = DigCntInit;
          state_d   = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CharMinus;
          last_d      = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          bcd_d     = bcd_q << DigitBits;
          dig_cnt_d = dig_cnt_q - 1'b1;
          // A leading zero is dropped unless it is the only digit left.
          if (top_digit != '0 || started_q || dig_cnt_q == '0) begin
            out_valid_d = 1'b1;
            char_d      = CharZero + CharBits'(top_digit);
            last_d      = (dig_cnt_q == '0);
            started_d   = 1'b1;
            if (dig_cnt_q == '0) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

// ===== rtl/sitoa_checker.sv =====
// Port-level checker for the signed integer to decimal ASCII converter,
// bound to the top level. Depends on sitoa_pkg for the character codes.

module sitoa_checker
  import sitoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DefaultValueBits
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [CharBits-1:0]   character_o,
  input logic                  last_char_o
);

  // Only a minus sign or a decimal digit is ever shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CharMinus ||
                     (character_o >= CharZero && character_o <= CharZero + 6'd9)))
    else $error("character out of range");

  // A minus sign is never the end of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && character_o == CharMinus) |-> !last_char_o)
    else $error("run ends on a minus sign");

  // Once an item is taken, the block is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transaction");

  // A new item is only taken once the pending run has reached its last character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && out_valid_o) |-> last_char_o)
    else $error("input ready in the middle of a run");

  // A held output stays unchanged until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(character_o) &&
                                       $stable(last_char_o)))
    else $error("stalled output changed");

endmodule

bind signed_int_to_decimal_ascii_top sitoa_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_sitoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .last_char_o (last_char_o)
);
